[hw/rtl/nss_pkg.sv]
// nss_pkg: shared types and constants for the NFA subset step block.
// Holds the sequencer state type, function codes and fixed field widths.
// No dependencies.
package nss_pkg;

	localparam int DATA_W  = 64;
	localparam int STATE_W = 6;
	localparam int SYM_W   = 4;

	// function codes carried by the func field
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_STEP  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} nss_state_t;

endpackage

[hw/rtl/nss_row_mem.sv]
// nss_row_mem: single-port-write, single-port-read synchronous row memory.
// Read data is registered. Depends on nothing.
module nss_row_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int W     = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/nfa_subset_step.sv]
// nfa_subset_step: one subset-construction step of a bit-parallel NFA.
// Depends on nss_pkg and nss_row_mem.
// Input channel (in_valid / in_stall) carries one transaction per item.
//   func = write stores row_mask (bits at or above NUM_STATES cleared) at
//   (src_state, symbol); out-of-range state or symbol is dropped. A write
//   produces no result.
//   func = step scans the successor table under symbol for every state of
//   current_set and returns the union on next_set, with no_successor set
//   when the union is empty. A symbol out of range returns an empty set.
// Output channel (out_valid / out_stall) holds one result in a register.
// Timing: the table lives in one synchronous memory, read for one source
//   state per cycle. A step occupies the block through accept, scan, read
//   drain and result load; out_valid is set by the result load. The
//   result register frees the input side: a new item is taken while a
//   result still waits; a step that finishes while the output is stalled
//   holds until it drains.
// Reset: after arst_n releases, a clearing pass writes zero to all
//   NUM_STATES*NUM_SYMBOLS rows, one per cycle; in_stall stays high
//   during that pass.
module nfa_subset_step #(
	parameter int NUM_STATES  = 64,
	parameter int NUM_SYMBOLS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        func,
	input  logic [nss_pkg::STATE_W-1:0] src_state,
	input  logic [nss_pkg::SYM_W-1:0]   symbol,
	input  logic [nss_pkg::DATA_W-1:0]  row_mask,
	input  logic [nss_pkg::DATA_W-1:0]  current_set,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [nss_pkg::DATA_W-1:0]  next_set,
	output logic                        no_successor
);

	localparam int ROWS = NUM_STATES * NUM_SYMBOLS;
	localparam int AW   = $clog2(ROWS);
	localparam int SW   = $clog2(NUM_STATES);
	localparam logic [nss_pkg::DATA_W-1:0] STATE_MASK = (NUM_STATES >= nss_pkg::DATA_W) ?
		{nss_pkg::DATA_W{1'b1}} :
		((nss_pkg::DATA_W'(1) << NUM_STATES) - nss_pkg::DATA_W'(1));

	nss_pkg::nss_state_t state_q, state_d;

	logic [AW-1:0]                clr_q;
	logic [SW-1:0]                idx_q;
	logic [AW-1:0]                addr_q;     // row of current scan state
	logic [NUM_STATES-1:0]        cur_q;      // remaining states, LSB = idx_q
	logic                         sym_ok_q;
	logic                         hit_s1;     // read issued last cycle counts
	logic [nss_pkg::DATA_W-1:0]   acc_q;
	logic                         out_valid_q;
	logic [nss_pkg::DATA_W-1:0]   next_set_q;
	logic                         no_succ_q;

	logic                         in_acc;
	logic                         out_free;
	logic                         load_out;
	logic                         wr_ok;
	logic                         mem_we;
	logic [AW-1:0]                mem_waddr;
	logic [nss_pkg::DATA_W-1:0]   mem_wdata;
	logic                         mem_re;
	logic [nss_pkg::DATA_W-1:0]   mem_rdata;
	logic [AW-1:0]                wr_row;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// write lands only for a state and symbol inside the table
	assign wr_ok = ({1'b0, src_state} < (nss_pkg::STATE_W + 1)'(NUM_STATES)) &&
		({5'b0, symbol} < 9'(NUM_SYMBOLS));
	assign wr_row = AW'(AW'(src_state) * AW'(NUM_SYMBOLS)) + AW'(symbol);

	// next state and datapath controls
	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = wr_row;
		mem_wdata = row_mask & STATE_MASK;
		mem_re    = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			nss_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == AW'(ROWS - 1)) begin
					state_d = nss_pkg::ST_IDLE;
				end
			end
			nss_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (func == nss_pkg::FUNC_WRITE) begin
						mem_we = wr_ok;
					end else begin
						state_d = nss_pkg::ST_SCAN;
					end
				end
			end
			nss_pkg::ST_SCAN: begin
				mem_re = cur_q[0] && sym_ok_q;
				if (idx_q == SW'(NUM_STATES - 1)) begin
					state_d = nss_pkg::ST_DRAIN;
				end
			end
			nss_pkg::ST_DRAIN: begin
				state_d = nss_pkg::ST_DONE;
			end
			nss_pkg::ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = nss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nss_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nss_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// clear sweep and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			idx_q  <= '0;
			hit_s1 <= 1'b0;
		end else begin
			if (state_q == nss_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (in_acc) begin
				idx_q <= '0;
			end else if (state_q == nss_pkg::ST_SCAN) begin
				idx_q <= idx_q + SW'(1);
			end
			hit_s1 <= mem_re;
		end
	end

	// scan payload: remaining state bits and row address
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cur_q    <= current_set[NUM_STATES-1:0];
			addr_q   <= AW'(symbol);
			sym_ok_q <= ({5'b0, symbol} < 9'(NUM_SYMBOLS));
		end else if (state_q == nss_pkg::ST_SCAN) begin
			cur_q  <= cur_q >> 1;
			addr_q <= addr_q + AW'(NUM_SYMBOLS);
		end
	end

	// union of successor rows, one row per cycle
	always_ff @(posedge clk) begin
		if (in_acc) begin
			acc_q <= '0;
		end else if (hit_s1) begin
			acc_q <= acc_q | mem_rdata;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			next_set_q <= acc_q;
			no_succ_q  <= (acc_q == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign next_set     = next_set_q;
	assign no_successor = no_succ_q;

	nss_row_mem #(
		.DEPTH (ROWS),
		.AW    (AW),
		.W     (nss_pkg::DATA_W)
	) u_rows (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (addr_q),
		.rdata (mem_rdata)
	);

	// a counted read always comes from a scan cycle
	a_hit_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		hit_s1 |-> $past(state_q) == nss_pkg::ST_SCAN)
		else $error("row read counted outside a scan");

	// no table write while a step is in flight
	a_no_write_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == nss_pkg::ST_CLEAR || state_q == nss_pkg::ST_IDLE))
		else $error("table write during a step");

	// the empty flag agrees with the set it describes
	a_flag_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> no_successor == (next_set == '0))
		else $error("no_successor disagrees with next_set");

	// results never name states beyond the automaton
	a_states_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (next_set & ~STATE_MASK) == '0)
		else $error("next_set holds a state out of range");

	// a waiting result is never overwritten by a finishing step
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !load_out)
		else $error("stalled result overwritten");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking bench for nfa_subset_step (row writes and subset steps).
// Depends on nss_pkg and the nfa_subset_step RTL; keeps its own copy of the transition table.
module testbench;

	localparam int NUM_STATES  = 64;
	localparam int NUM_SYMBOLS = 16;
	localparam int ROWS        = NUM_STATES * NUM_SYMBOLS;
	localparam logic [nss_pkg::DATA_W-1:0] STATE_MASK =
		(NUM_STATES >= nss_pkg::DATA_W) ? '1 : ((64'd1 << NUM_STATES) - 64'd1);

	localparam int RANDOM_ITEMS = 1230;
	localparam int CHUNK        = 160;          // random transactions per pacing phase
	localparam int HOLD_CYCLES  = 600;          // long output hold-off under pressure
	localparam int DRAIN_CYCLES = NUM_STATES + 16;
	// slowest run: clear pass, ~1250 transactions plus stalls and gaps; several times over
	localparam longint CYCLE_LIMIT = 1000000;

	// how both sides pace themselves while a transaction of this phase is in flight
	typedef enum logic [2:0] {
		PACE_FREE,
		PACE_SRC_IDLE,
		PACE_SINK_STALL,
		PACE_BOTH,
		PACE_PRESSURE
	} pace_t;

	typedef struct packed {
		logic                        func;
		logic [nss_pkg::STATE_W-1:0] src;
		logic [nss_pkg::SYM_W-1:0]   sym;
		logic [nss_pkg::DATA_W-1:0]  row;
		logic [nss_pkg::DATA_W-1:0]  cur;
		pace_t                       pace;
	} txn_t;

	typedef struct packed {
		logic [nss_pkg::DATA_W-1:0] succ;
		logic                       empty;
	} succ_t;

	logic                         clk          = 1'b0;
	logic                         arst_n       = 1'b0;
	logic                         in_valid     = 1'b0;
	logic                         in_stall;
	logic                         func         = nss_pkg::FUNC_WRITE;
	logic [nss_pkg::STATE_W-1:0]  src_state    = '0;
	logic [nss_pkg::SYM_W-1:0]    symbol       = '0;
	logic [nss_pkg::DATA_W-1:0]   row_mask     = '0;
	logic [nss_pkg::DATA_W-1:0]   current_set  = '0;
	logic                         out_valid;
	logic                         out_stall    = 1'b0;
	logic [nss_pkg::DATA_W-1:0]   next_set;
	logic                         no_successor;

	nfa_subset_step #(
		.NUM_STATES (NUM_STATES),
		.NUM_SYMBOLS(NUM_SYMBOLS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.src_state   (src_state),
		.symbol      (symbol),
		.row_mask    (row_mask),
		.current_set (current_set),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.next_set    (next_set),
		.no_successor(no_successor)
	);

	always #6 clk = ~clk;

	// Shadow transition table and the successor sets still owed by the block.
	logic [nss_pkg::DATA_W-1:0] trans_table [ROWS];
	txn_t              item_q[$];
	succ_t             succ_q[$];

	txn_t   offered;                 // transaction currently on the input port
	pace_t  pace         = PACE_FREE;
	int     hold_left    = 0;
	bit     pressure_seen = 1'b0;
	longint cycles       = 0;
	int     errors       = 0;
	int     row_writes   = 0;
	int     steps        = 0;
	int     results      = 0;
	int     empty_sets   = 0;
	int     backed_up    = 0;

	function automatic bit coin(int pct);
		return $urandom_range(99) < pct;
	endfunction

	// Random 64-bit mask with a mix of shapes: empty, full, one or two bits, dense random.
	function automatic logic [nss_pkg::DATA_W-1:0] shaped_mask();
		logic [nss_pkg::DATA_W-1:0] m;
		case ($urandom_range(9))
			0: m = '0;
			1: m = '1;
			2: m = 64'd1 << $urandom_range(63);
			3: m = (64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63));
			default: m = {$urandom, $urandom};
		endcase
		return m;
	endfunction

	function automatic void queue_item(logic f, logic [nss_pkg::STATE_W-1:0] s,
			logic [nss_pkg::SYM_W-1:0] a, logic [nss_pkg::DATA_W-1:0] row,
			logic [nss_pkg::DATA_W-1:0] cur, pace_t p);
		txn_t t;
		t.func = f;
		t.src  = s;
		t.sym  = a;
		t.row  = row;
		t.cur  = cur;
		t.pace = p;
		item_q.insert(item_q.size(), t);
	endfunction

	// Apply one accepted transaction to the shadow table; a step owes one successor set.
	function automatic void track_transaction(txn_t t);
		logic [nss_pkg::DATA_W-1:0] live;
		succ_t                      r;
		live   = t.cur & STATE_MASK;
		r.succ = '0;
		if (t.func == nss_pkg::FUNC_WRITE) begin
			row_writes++;
			// out-of-range state or symbol writes are dropped; high row bits never stored
			if (int'(t.src) < NUM_STATES && int'(t.sym) < NUM_SYMBOLS)
				trans_table[int'(t.src) * NUM_SYMBOLS + int'(t.sym)] = t.row & STATE_MASK;
		end else begin
			steps++;
			// a symbol out of range gives the empty set
			if (int'(t.sym) < NUM_SYMBOLS) begin
				for (int s = 0; s < NUM_STATES && s < nss_pkg::DATA_W; s++)
					if (live[s])
						r.succ |= trans_table[s * NUM_SYMBOLS + int'(t.sym)];
			end
			r.empty = (r.succ == '0);
			succ_q.insert(succ_q.size(), r);
		end
	endfunction

	// Driver: a transaction moves when valid is high and stall is low at the edge.
	// The payload stays put while stalled; idle gaps are only taken between transactions.
	always @(posedge clk) begin : drive
		bit   rest;
		txn_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				track_transaction(offered);
			rest = (item_q.size() != 0) &&
				((item_q[0].pace == PACE_SRC_IDLE && coin(59)) ||
				 (item_q[0].pace == PACE_BOTH && coin(38)));
			if (item_q.size() != 0 && !rest) begin
				nxt = item_q.pop_front();
				func         <= nxt.func;
				src_state    <= nxt.src;
				symbol       <= nxt.sym;
				row_mask     <= nxt.row;
				current_set  <= nxt.cur;
				offered      <= nxt;
				pace         <= nxt.pace;
				in_valid     <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each accepted result against the oldest owed successor set,
	// then pick the stall for the next cycle.
	always @(posedge clk) begin : watch
		succ_t want;
		if (arst_n && out_valid && !out_stall) begin
			results++;
			if (no_successor)
				empty_sets++;
			if (succ_q.size() == 0) begin
				errors++;
				$display("%0t: result with nothing owed: next_set=%h no_successor=%b",
					$time, next_set, no_successor);
			end else begin
				want = succ_q.pop_front();
				if (next_set !== want.succ) begin
					errors++;
					$display("%0t: next_set expected %h actual %h", $time, want.succ, next_set);
				end
				if (no_successor !== want.empty) begin
					errors++;
					$display("%0t: no_successor expected %b actual %b",
						$time, want.empty, no_successor);
				end
			end
		end
		out_stall <= (hold_left != 0) ||
			(pace == PACE_SINK_STALL && coin(59)) ||
			(pace == PACE_BOTH && coin(38));
	end

	// Pressure: on entering a pressure phase the receiver holds off for a long stretch
	// while the sender keeps offering; the result register fills and the input backs up.
	always @(posedge clk) begin
		if (pace == PACE_PRESSURE && !pressure_seen) begin
			hold_left     <= HOLD_CYCLES;
			pressure_seen <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
		if (pace != PACE_PRESSURE)
			pressure_seen <= 1'b0;
		if (hold_left != 0 && in_valid && in_stall)
			backed_up++;
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("nfa_subset_step verification failed");
			$finish;
		end
	end

	initial begin : main
		logic       f;
		pace_t      p;
		for (int i = 0; i < ROWS; i++)
			trans_table[i] = '0;

		// Directed: unwritten rows, extreme states and symbols, empty and full sets,
		// overwrite to zero, and junk in the field each function ignores.
		queue_item(nss_pkg::FUNC_STEP,  6'd0,  4'd0,  '1, '1, PACE_FREE);
		queue_item(nss_pkg::FUNC_STEP,  6'd0,  4'd15, '1, '0, PACE_FREE);
		queue_item(nss_pkg::FUNC_WRITE, 6'd0,  4'd0,  '1, '1, PACE_FREE);
		queue_item(nss_pkg::FUNC_WRITE, 6'd63, 4'd15, 64'h8000_0000_0000_0000, '1, PACE_FREE);
		queue_item(nss_pkg::FUNC_WRITE, 6'd63, 4'd0,  64'd1, 64'hDEAD_BEEF_0123_4567,
			PACE_FREE);
		queue_item(nss_pkg::FUNC_WRITE, 6'd0,  4'd15, 64'hAAAA_AAAA_AAAA_AAAA, '0, PACE_FREE);
		queue_item(nss_pkg::FUNC_WRITE, 6'd1,  4'd0,  64'h5555_5555_5555_5555, '1, PACE_FREE);
		queue_item(nss_pkg::FUNC_STEP,  6'd63, 4'd0,  64'hFFFF_0000_FFFF_0000, 64'd1,
			PACE_FREE);
		queue_item(nss_pkg::FUNC_STEP,  6'd0,  4'd0,  '1, 64'h8000_0000_0000_0000, PACE_FREE);
		queue_item(nss_pkg::FUNC_STEP,  6'd0,  4'd15, '0, '1, PACE_FREE);
		queue_item(nss_pkg::FUNC_STEP,  6'd0,  4'd15, '1, '0, PACE_FREE);
		queue_item(nss_pkg::FUNC_STEP,  6'd0,  4'd0,  '0, 64'd2, PACE_FREE);
		queue_item(nss_pkg::FUNC_WRITE, 6'd0,  4'd0,  '0, '1, PACE_FREE);
		queue_item(nss_pkg::FUNC_STEP,  6'd0,  4'd0,  '1, 64'd1, PACE_FREE);
		queue_item(nss_pkg::FUNC_STEP,  6'd0,  4'd0,  '0, '1, PACE_FREE);
		queue_item(nss_pkg::FUNC_STEP,  6'd0,  4'd7,  '1, '1, PACE_FREE);
		queue_item(nss_pkg::FUNC_WRITE, 6'd32, 4'd7,  64'h0000_0001_0000_0000, '0, PACE_FREE);
		queue_item(nss_pkg::FUNC_STEP,  6'd5,  4'd7,  '1, 64'h0000_0001_0000_0000, PACE_FREE);
		queue_item(nss_pkg::FUNC_STEP,  6'd0,  4'd15, '1, 64'h8000_0000_0000_0000, PACE_FREE);
		queue_item(nss_pkg::FUNC_STEP,  6'd63, 4'd15, '0, 64'h8000_0000_0000_0001, PACE_FREE);

		// Random: row writes mixed with steps, random junk in the unused field,
		// pacing phase rotating every chunk.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			p = pace_t'((n / CHUNK) % 5);
			f = coin(45) ? nss_pkg::FUNC_WRITE : nss_pkg::FUNC_STEP;
			queue_item(f, nss_pkg::STATE_W'($urandom_range(63)),
				nss_pkg::SYM_W'($urandom_range(15)), shaped_mask(), shaped_mask(), p);
		end

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// wait for every transaction to be taken and every owed result to arrive;
		// sampled mid-cycle so the driver's updates have settled
		while (item_q.size() != 0 || in_valid || succ_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d row writes and %0d steps; %0d successor sets checked, %0d empty.",
			row_writes, steps, results, empty_sets);
		$display("Input held back %0d cycles during output hold-offs; %0d mismatches.",
			backed_up, errors);
		if (errors == 0) begin
			$display("nfa_subset_step verification clean");
		end else begin
			$display("nfa_subset_step verification failed");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/nss_pkg.sv
hw/rtl/nss_row_mem.sv
hw/rtl/nfa_subset_step.sv
tb/testbench.sv
